>>> design/tilt_angle_and_quadrature_sampler_macros.svh
// Assertion macros used by the top-level design file.
`ifndef TILT_ANGLE_AND_QUADRATURE_SAMPLER_MACROS_SVH
`define TILT_ANGLE_AND_QUADRATURE_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tas_pkg.sv
`default_nettype none

package tas_pkg;

	// Input transaction layout (bit positions within s_tdata).
	localparam int IN_W        = 64;
	localparam int AXIS_W      = 16;
	localparam int ADC_W       = 12;
	localparam int ANGLE_W     = 16;
	localparam int X_LSB       = 0;
	localparam int Y_LSB       = 16;
	localparam int Z_LSB       = 32;
	localparam int ADC_LSB     = 48;
	localparam int ENC_A_BIT   = 60;
	localparam int ENC_B_BIT   = 61;
	localparam int SINK_RDY_BIT = 62;

	// Arithmetic widths.
	localparam int SQ_W        = 32;
	localparam int RAD_W       = 48;
	localparam int ROOT_W      = 24;
	localparam int REM_W       = 27;
	localparam int VEC_W       = 36;
	localparam int ANG_ACC_W   = 20;
	localparam int ATAN_W      = 17;
	localparam int STEP_W      = 4;
	localparam int ROOT_LAST   = 11;
	localparam int ROT_LAST    = 15;
	localparam int HALF_PI_Q16 = 102944;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_SQY,
		ENG_SQZ,
		ENG_ROOT,
		ENG_ROT,
		ENG_DONE
	} tas_eng_state_t;

	typedef struct packed {
		logic start;
		logic take;
	} tas_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} tas_sts_t;

	// Arctangent of 2^-i in Q16 radians, rounded.
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			4'd0:    v = 17'd51472;
			4'd1:    v = 17'd30386;
			4'd2:    v = 17'd16055;
			4'd3:    v = 17'd8150;
			4'd4:    v = 17'd4091;
			4'd5:    v = 17'd2047;
			4'd6:    v = 17'd1024;
			4'd7:    v = 17'd512;
			4'd8:    v = 17'd256;
			4'd9:    v = 17'd128;
			4'd10:   v = 17'd64;
			4'd11:   v = 17'd32;
			4'd12:   v = 17'd16;
			4'd13:   v = 17'd8;
			4'd14:   v = 17'd4;
			4'd15:   v = 17'd2;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> design/tas_engine.sv
`default_nettype none

module tas_engine import tas_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 14
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tas_ctl_t                  ctl,
	input  wire logic signed [AXIS_W-1:0]  accel_x,
	input  wire logic signed [AXIS_W-1:0]  accel_y,
	input  wire logic signed [AXIS_W-1:0]  accel_z,
	output tas_sts_t                       sts,
	output logic signed [ANGLE_W-1:0]      tilt_angle
);

	localparam int SH        = 16 - ANGLE_FRAC_BITS;
	localparam int HALF_UNIT = 1 << (SH - 1);

	tas_eng_state_t state_q, state_nx;

	logic signed [AXIS_W-1:0]    y_q, z_q;
	logic [SQ_W-1:0]             s_q;
	logic [RAD_W-1:0]            n_q;
	logic [REM_W-1:0]            rem_q;
	logic [ROOT_W-1:0]           root_q;
	logic [STEP_W-1:0]           cnt_q;
	logic signed [VEC_W-1:0]     cx_q, cy_q;
	logic signed [ANG_ACC_W-1:0] ang_q;

	// Shared squarer: Y in state ENG_SQY, then Z in state ENG_SQZ.
	logic signed [AXIS_W-1:0]    mul_in;
	logic signed [SQ_W-1:0]      prod;
	logic [SQ_W-1:0]             sum_sq;

	assign mul_in = (state_q == ENG_SQY) ? y_q : z_q;
	assign prod   = mul_in * mul_in;
	assign sum_sq = s_q + SQ_W'(prod);

	// One digit of the restoring square root: returns {remainder, root}.
	function automatic logic [REM_W+ROOT_W-1:0] root_step(
		input logic [REM_W-1:0]  r,
		input logic [ROOT_W-1:0] q,
		input logic [1:0]        bits
	);
		logic [REM_W-1:0] rt;
		logic [REM_W-1:0] tr;
		rt = {r[REM_W-3:0], bits};
		tr = {1'b0, q, 2'b01};
		if (rt >= tr) begin
			return {rt - tr, q[ROOT_W-2:0], 1'b1};
		end
		return {rt, q[ROOT_W-2:0], 1'b0};
	endfunction

	logic [REM_W+ROOT_W-1:0] st1, st2;

	always_comb begin
		st1 = root_step(rem_q, root_q, n_q[RAD_W-1:RAD_W-2]);
		st2 = root_step(st1[REM_W+ROOT_W-1:ROOT_W], st1[ROOT_W-1:0], n_q[RAD_W-3:RAD_W-4]);
	end

	// CORDIC micro-rotation with the old vector components.
	logic signed [VEC_W-1:0]     sx, sy;
	logic signed [ANG_ACC_W-1:0] t_i;

	assign sx  = cx_q >>> cnt_q;
	assign sy  = cy_q >>> cnt_q;
	assign t_i = signed'(ANG_ACC_W'(atan_q16(cnt_q)));

	// Start vector: cy = -x * 2^16.
	logic signed [VEC_W-1:0] cy_init;
	assign cy_init = -(VEC_W'(accel_x) <<< 16);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ENG_IDLE: begin
				if (ctl.start) begin
					state_nx = (accel_x == '0) ? ENG_DONE : ENG_SQY;
				end
			end
			ENG_SQY:  state_nx = ENG_SQZ;
			ENG_SQZ:  state_nx = ENG_ROOT;
			ENG_ROOT: begin
				if (cnt_q == STEP_W'(ROOT_LAST)) begin
					state_nx = ENG_ROT;
				end
			end
			ENG_ROT: begin
				if (cnt_q == STEP_W'(ROT_LAST)) begin
					state_nx = ENG_DONE;
				end
			end
			ENG_DONE: begin
				if (ctl.take) begin
					state_nx = ENG_IDLE;
				end
			end
			default:  state_nx = ENG_IDLE;
		endcase
	end

	always_comb begin
		sts.idle = (state_q == ENG_IDLE);
		sts.done = (state_q == ENG_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ENG_IDLE: begin
				if (ctl.start) begin
					y_q   <= accel_y;
					z_q   <= accel_z;
					cy_q  <= cy_init;
					ang_q <= '0;
				end
			end
			ENG_SQY: begin
				s_q <= SQ_W'(prod);
			end
			ENG_SQZ: begin
				n_q    <= {sum_sq, 16'b0};
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			ENG_ROOT: begin
				n_q    <= n_q << 4;
				rem_q  <= st2[REM_W+ROOT_W-1:ROOT_W];
				root_q <= st2[ROOT_W-1:0];
				if (cnt_q == STEP_W'(ROOT_LAST)) begin
					cx_q  <= VEC_W'(st2[ROOT_W-1:0]) <<< 8;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ENG_ROT: begin
				if (!cy_q[VEC_W-1]) begin
					cx_q  <= cx_q + sy;
					cy_q  <= cy_q - sx;
					ang_q <= ang_q + t_i;
				end else begin
					cx_q  <= cx_q - sy;
					cy_q  <= cy_q + sx;
					ang_q <= ang_q - t_i;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Clamp to plus or minus pi/2, then round to the output scale.
	localparam logic signed [ANG_ACC_W-1:0] ANG_LIM  = ANG_ACC_W'(HALF_PI_Q16);
	localparam logic signed [ANG_ACC_W-1:0] ANG_HALF = ANG_ACC_W'(HALF_UNIT);

	logic signed [ANG_ACC_W-1:0] ang_cl, ang_rnd;

	always_comb begin
		if (ang_q > ANG_LIM) begin
			ang_cl = ANG_LIM;
		end else if (ang_q < -ANG_LIM) begin
			ang_cl = -ANG_LIM;
		end else begin
			ang_cl = ang_q;
		end
		ang_rnd    = (ang_cl + ANG_HALF) >>> SH;
		tilt_angle = ang_rnd[ANGLE_W-1:0];
	end

endmodule

`default_nettype wire

>>> design/tilt_angle_and_quadrature_sampler.sv
// Tilt angle and quadrature sampler.
// Input channel s_*: one transaction is one sample set (three accelerometer axes,
// an ADC reading, the two encoder line levels and the sink-ready flag).
// Output channel m_*: one transaction is one record (angle, ADC value, count).
// Every accepted sample updates the encoder count at once: when line A differs
// from its previous level the count steps down if A differs from B and up
// otherwise, saturating at its signed limits. A record is produced only for a
// sample that changes line A while its sink-ready flag is set.
// A sample that produces no record leaves s_tready high.
// A sample that produces a record occupies the angle engine from acceptance to
// the record in the output register: Y and Z on the shared squarer in turn,
// twelve square-root iterations at two bits each and sixteen CORDIC
// rotations, one per cycle; a zero X axis skips straight to a zero angle.
// s_tready is low while the engine works. If the receiver stalls, the record
// waits in the output register and the engine accepts and computes the next
// sample, then holds its result until the output register frees up.
// Reset clears the previous A level to zero and sets the count to one.
`default_nettype none
`include "tilt_angle_and_quadrature_sampler_macros.svh"

module tilt_angle_and_quadrature_sampler import tas_pkg::*; #(
	parameter int COUNT_WIDTH     = 24,
	parameter int ANGLE_FRAC_BITS = 14
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// accel_x[15:0], accel_y[31:16], accel_z[47:32], adc_sample[59:48],
	// enc_a[60], enc_b[61], sink_ready[62], zero pad[63]
	input  wire logic [IN_W-1:0]        s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// tilt_angle[15:0], adc_value[27:16], position_count[27+COUNT_WIDTH:28],
	// zero pad up to the byte boundary
	output logic [((ANGLE_W + ADC_W + COUNT_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int OUT_BITS = ANGLE_W + ADC_W + COUNT_WIDTH;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
	localparam int SH       = 16 - ANGLE_FRAC_BITS;
	localparam int ANG_MAX  = (HALF_PI_Q16 + (1 << (SH - 1))) >> SH;

	localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	// Input fields.
	logic enc_a, enc_b, sink_ready, s_accept;

	assign enc_a      = s_tdata[ENC_A_BIT];
	assign enc_b      = s_tdata[ENC_B_BIT];
	assign sink_ready = s_tdata[SINK_RDY_BIT];
	assign s_accept   = s_tvalid && s_tready;

	// Encoder state.
	logic                          prev_a_q;
	logic signed [COUNT_WIDTH-1:0] count_q, count_nx;
	logic                          a_change, emit;

	assign a_change = (enc_a != prev_a_q);
	assign emit     = s_accept && a_change && sink_ready;

	always_comb begin
		count_nx = count_q;
		if (a_change) begin
			if (enc_a != enc_b) begin
				if (count_q != CMIN) begin
					count_nx = count_q - 1'b1;
				end
			end else begin
				if (count_q != CMAX) begin
					count_nx = count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= 1'b0;
			count_q  <= COUNT_WIDTH'(1);
		end else if (s_accept) begin
			prev_a_q <= enc_a;
			count_q  <= count_nx;
		end
	end

	// Record fields that travel beside the angle computation.
	logic [ADC_W-1:0]       adc_q;
	logic [COUNT_WIDTH-1:0] rec_count_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			adc_q       <= s_tdata[ADC_LSB +: ADC_W];
			rec_count_q <= count_nx;
		end
	end

	// Angle engine.
	tas_ctl_t                  eng_ctl;
	tas_sts_t                  eng_sts;
	logic signed [ANGLE_W-1:0] eng_angle;
	logic                      out_load;

	assign out_load      = eng_sts.done && (!m_tvalid || m_tready);
	assign eng_ctl.start = emit;
	assign eng_ctl.take  = out_load;
	assign s_tready      = eng_sts.idle;

	tas_engine #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (eng_ctl),
		.accel_x   (s_tdata[X_LSB +: AXIS_W]),
		.accel_y   (s_tdata[Y_LSB +: AXIS_W]),
		.accel_z   (s_tdata[Z_LSB +: AXIS_W]),
		.sts       (eng_sts),
		.tilt_angle(eng_angle)
	);

	// Output register: decouples the engine from a stalled receiver.
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [OUT_W-1:0] rec_pack;

	always_comb begin
		rec_pack                = '0;
		rec_pack[OUT_BITS-1:0]  = {rec_count_q, adc_q, eng_angle};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= rec_pack;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A sample that leaves line A unchanged must not move the count.
	`TAS_ASSERT_NEXT(a_count_hold, clk, arst_n, s_accept && !a_change, count_q == $past(count_q), "count moved without a change of line A")
	// The count moves by at most one step per transaction.
	`TAS_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1), "count jumped by more than one")
	// A finished angle handed to the output register must show up as a valid record.
	`TAS_ASSERT_NEXT(a_load_valid, clk, arst_n, out_load, m_tvalid_q, "record lost on load")
	// The emitted angle never leaves plus or minus pi/2.
	`TAS_ASSERT_IMPL(a_angle_range, clk, arst_n, m_tvalid_q, (signed'(m_tdata_q[ANGLE_W-1:0]) <= signed'(ANGLE_W'(ANG_MAX))) && (signed'(m_tdata_q[ANGLE_W-1:0]) >= -signed'(ANGLE_W'(ANG_MAX))), "angle out of range")

endmodule

`default_nettype wire
